// ===== hdl/zbh_pkg.sv =====
// ----------------------------------------------------------------------------
// zbh_pkg
// Shared types and constants of the Zobrist board hash: board size, mixer
// constants and the state encodings of both sequencers.
// ----------------------------------------------------------------------------
package zbh_pkg;

    localparam int unsigned BOARD_SIZE = 64;

    localparam int unsigned KEY_W     = 64;
    localparam int unsigned HALF_W    = KEY_W / 2;
    localparam int unsigned SQUARE_W  = 7;
    localparam int unsigned PIECE_W   = 4;

    // Wide enough to compare a square against a board size of up to 128
    localparam int unsigned SQ_CMP_W  = SQUARE_W + 1;
    // Counter 2 + piece * BOARD_SIZE + square stays below 2^12 for every size
    localparam int unsigned COUNT_W   = 12;

    localparam logic [KEY_W-1:0]   MIX_MULT     = 64'h9FB21C651E98DF25;
    localparam int unsigned        ROT_A        = 49;
    localparam int unsigned        ROT_B        = 24;
    localparam int unsigned        SHIFT_1      = 35;
    localparam int unsigned        SHIFT_2      = 28;
    localparam logic [COUNT_W-1:0] COUNTER_BASE = 12'd2;
    localparam logic [KEY_W-1:0]   SIDE_COUNTER = 64'd1;

    typedef enum logic
    {
        MIX_IDLE,
        MIX_RUN
    } mix_state_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ITEM_MIX,
        ST_SIDE_MIX,
        ST_FINISH
    } hash_state_t;

endpackage

// ===== hdl/zbh_mul32.sv =====
// ----------------------------------------------------------------------------
// zbh_mul32
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module zbh_mul32
(
    input  logic                          clk,
    input  logic [zbh_pkg::HALF_W-1:0]    a,
    input  logic [zbh_pkg::HALF_W-1:0]    b,
    output logic [zbh_pkg::KEY_W-1:0]     prod
);

    logic [zbh_pkg::KEY_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= zbh_pkg::KEY_W'(a) * zbh_pkg::KEY_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/zbh_mixer.sv =====
// ----------------------------------------------------------------------------
// zbh_mixer
// Rotate-xor-multiply mixer. Each 64-bit multiply by the constant is built
// from three 32 x 32 partial products on the shared multiplier, two passes
// per word.
// ----------------------------------------------------------------------------
module zbh_mixer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [zbh_pkg::KEY_W-1:0]     start_value,
    output logic                          done,
    output logic [zbh_pkg::KEY_W-1:0]     result
);

    localparam logic [zbh_pkg::HALF_W-1:0] MULT_LO = zbh_pkg::MIX_MULT[zbh_pkg::HALF_W-1:0];
    localparam logic [zbh_pkg::HALF_W-1:0] MULT_HI =
        zbh_pkg::MIX_MULT[zbh_pkg::KEY_W-1:zbh_pkg::HALF_W];

    zbh_pkg::mix_state_t state_reg, state_next;
    logic [1:0]                  step_reg, step_next;
    logic                        pass_reg, pass_next;
    logic [zbh_pkg::KEY_W-1:0]   n_reg, n_next;
    logic [zbh_pkg::KEY_W-1:0]   acc_reg, acc_next;

    logic [zbh_pkg::HALF_W-1:0]  mul_a;
    logic [zbh_pkg::HALF_W-1:0]  mul_b;
    logic [zbh_pkg::KEY_W-1:0]   prod;
    logic [zbh_pkg::KEY_W-1:0]   premix;
    logic [zbh_pkg::KEY_W-1:0]   sum;
    logic [zbh_pkg::KEY_W-1:0]   shifted;

    zbh_mul32 u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Low 64 bits of n * C: lo*lo + ((lo*hi + hi*lo) << 32)
    assign mul_a = (step_reg == 2'd2) ? n_reg[zbh_pkg::KEY_W-1:zbh_pkg::HALF_W]
                                      : n_reg[zbh_pkg::HALF_W-1:0];
    assign mul_b = (step_reg == 2'd1) ? MULT_HI : MULT_LO;

    assign premix = start_value
                  ^ ((start_value << zbh_pkg::ROT_A)
                     | (start_value >> (zbh_pkg::KEY_W - zbh_pkg::ROT_A)))
                  ^ ((start_value << zbh_pkg::ROT_B)
                     | (start_value >> (zbh_pkg::KEY_W - zbh_pkg::ROT_B)));

    assign sum     = acc_reg + {prod[zbh_pkg::HALF_W-1:0], {zbh_pkg::HALF_W{1'b0}}};
    assign shifted = pass_reg ? (sum ^ (sum >> zbh_pkg::SHIFT_2))
                              : (sum ^ (sum >> zbh_pkg::SHIFT_1));

    assign result = shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zbh_pkg::MIX_IDLE;
            step_reg  <= 2'd0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        done       = 1'b0;

        unique case (state_reg)
            zbh_pkg::MIX_IDLE:
            begin
                if (start)
                begin
                    n_next     = premix;
                    step_next  = 2'd0;
                    pass_next  = 1'b0;
                    state_next = zbh_pkg::MIX_RUN;
                end
            end
            zbh_pkg::MIX_RUN:
            begin
                step_next = step_reg + 2'd1;
                unique case (step_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        acc_next = prod;
                    end
                    2'd2:
                    begin
                        acc_next = sum;
                    end
                    default:
                    begin
                        // Close the pass: fold in the last partial product and shift-xor
                        n_next    = shifted;
                        pass_next = ~pass_reg;
                        if (pass_reg)
                        begin
                            done = 1'b1;
                            // Take a chained start straight from the closing step
                            if (start)
                            begin
                                n_next = premix;
                            end
                            else
                            begin
                                state_next = zbh_pkg::MIX_IDLE;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = zbh_pkg::MIX_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/zobrist_board_hash.sv =====
// ----------------------------------------------------------------------------
// zobrist_board_hash
// Zobrist key of a board delivered one square per transaction.
// ----------------------------------------------------------------------------
// A board arrives one square per transaction; occupied squares inside the
// board XOR the word mix(2 + piece_code * BOARD_SIZE + square) into a 64-bit
// accumulator, and the transaction marked is_last adds mix(1) when white is to
// move, sends the key out and clears the accumulator. Words are computed on
// the fly by one mixer built around a single shared 32 x 32 multiplier: a word
// takes two multiply passes of three partial products, each closed by a fold.
// An empty or out-of-range square skips the mixer, a contributing square runs
// one word through it, and the last square adds any side word before the key
// is loaded. While a square is in work in_stall is high; the key sits in an
// output register, so the next board may start while it waits on out_stall.
// ----------------------------------------------------------------------------
module zobrist_board_hash
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [zbh_pkg::SQUARE_W-1:0]      square,
    input  logic [zbh_pkg::PIECE_W-1:0]       piece_code,
    input  logic                              occupied,
    input  logic                              white_to_move,
    input  logic                              is_last,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [zbh_pkg::KEY_W-1:0]         hash_key
);

    zbh_pkg::hash_state_t state_reg, state_next;
    logic                         last_reg, last_next;
    logic                         white_reg, white_next;
    logic [zbh_pkg::KEY_W-1:0]    acc_reg, acc_next;
    logic                         out_valid_reg, out_valid_next;
    logic [zbh_pkg::KEY_W-1:0]    hash_key_reg, hash_key_next;

    logic                         mix_start;
    logic [zbh_pkg::KEY_W-1:0]    mix_value;
    logic                         mix_done;
    logic [zbh_pkg::KEY_W-1:0]    mix_result;

    logic                         in_board;
    logic [zbh_pkg::COUNT_W-1:0]  counter;
    logic                         out_free;

    zbh_mixer u_mixer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mix_start),
        .start_value (mix_value),
        .done        (mix_done),
        .result      (mix_result)
    );

    assign in_board = zbh_pkg::SQ_CMP_W'(square) < zbh_pkg::SQ_CMP_W'(zbh_pkg::BOARD_SIZE);
    assign counter  = zbh_pkg::COUNTER_BASE
                    + zbh_pkg::COUNT_W'(piece_code) * zbh_pkg::COUNT_W'(zbh_pkg::BOARD_SIZE)
                    + zbh_pkg::COUNT_W'(square);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != zbh_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hash_key  = hash_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zbh_pkg::ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        white_reg    <= white_next;
        hash_key_reg <= hash_key_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        white_next     = white_reg;
        acc_next       = acc_reg;
        hash_key_next  = hash_key_reg;
        out_valid_next = out_valid_reg && out_stall;
        mix_start      = 1'b0;
        mix_value      = zbh_pkg::SIDE_COUNTER;

        unique case (state_reg)
            zbh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = is_last;
                    white_next = white_to_move;
                    if (occupied && in_board)
                    begin
                        mix_start  = 1'b1;
                        mix_value  = zbh_pkg::KEY_W'(counter);
                        state_next = zbh_pkg::ST_ITEM_MIX;
                    end
                    else if (is_last && white_to_move)
                    begin
                        mix_start  = 1'b1;
                        state_next = zbh_pkg::ST_SIDE_MIX;
                    end
                    else if (is_last)
                    begin
                        state_next = zbh_pkg::ST_FINISH;
                    end
                end
            end
            zbh_pkg::ST_ITEM_MIX:
            begin
                if (mix_done)
                begin
                    acc_next = acc_reg ^ mix_result;
                    if (last_reg && white_reg)
                    begin
                        state_next = zbh_pkg::ST_SIDE_MIX;
                    end
                    else if (last_reg)
                    begin
                        state_next = zbh_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = zbh_pkg::ST_IDLE;
                    end
                end
            end
            zbh_pkg::ST_SIDE_MIX:
            begin
                if (mix_done)
                begin
                    acc_next   = acc_reg ^ mix_result;
                    state_next = zbh_pkg::ST_FINISH;
                end
            end
            zbh_pkg::ST_FINISH:
            begin
                // Hold the key until the output register frees up
                if (out_free)
                begin
                    hash_key_next  = acc_reg;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = zbh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zbh_pkg::ST_IDLE;
            end
        endcase

        // Chain the side word straight after the square's word
        if (state_reg == zbh_pkg::ST_ITEM_MIX && mix_done && last_reg && white_reg)
        begin
            mix_start = 1'b1;
            mix_value = zbh_pkg::SIDE_COUNTER;
        end
    end

endmodule
